/* rtl/f2dc_pkg.sv */
// ----------------------------------------------------------------------------
// f2dc_pkg
// Shared types and constants for the float to decimal text converter.
// ----------------------------------------------------------------------------
package f2dc_pkg;

	localparam logic [6:0] CHAR_ZERO = 7'h30;
	localparam logic [6:0] CHAR_DOT  = 7'h2E;
	localparam logic [3:0] MAX_CHARS = 4'd9;
	localparam logic [30:0] DIV_CAP  = 31'h40000000;
	localparam logic [31:0] RESCALE_LIMIT = 32'h80000000 / 32'd10;
	localparam logic [7:0] EXP_LIMIT = 8'd151;
	localparam logic [7:0] EXP_BIAS_SHIFT = 8'd150;

	// classified item handed from the front end to the back end
	typedef struct packed {
		logic        flag;
		logic [23:0] mant;
		logic [30:0] divisor;
	} job_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_INT,
		ST_DOT,
		ST_FRAC_PREP,
		ST_FRAC_DIV,
		ST_FLAG
	} back_state_t;

	typedef struct packed {
		logic [6:0] text_char;
		logic       last_char;
		logic       out_of_range;
	} res_t;

endpackage

/* rtl/float_to_decimal_chars.sv */
// ----------------------------------------------------------------------------
// float_to_decimal_chars
// Float32 to decimal ASCII text, one character per output transaction.
// ----------------------------------------------------------------------------
// One conversion runs the integer division and emits its digits (more digits
// take longer), then runs one division per fraction digit, all on the
// bit-serial divider (one quotient bit per cycle); a held-off pop stalls the
// conversion. A two-entry queue lets the next float be pushed while a
// conversion runs.
module float_to_decimal_chars (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [31:0] float_bits,
	output logic        empty,
	input  logic        pop,
	output logic [6:0]  text_char,
	output logic        last_char,
	output logic        out_of_range,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_data
);
	logic [2:0] places_q;
	logic job_valid;
	logic job_take;
	f2dc_pkg::job_t job;
	logic res_valid;
	f2dc_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			places_q <= 3'd7;
		else if (cfg_we)
			places_q <= cfg_data;
	end

	f2dc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.float_bits(float_bits), .job_valid(job_valid), .job_take(job_take), .job(job)
	);

	f2dc_back u_back (
		.clk(clk), .arst_n(arst_n), .decimal_places(places_q),
		.job_valid(job_valid), .job_take(job_take), .job(job),
		.res_valid(res_valid), .res_take(pop), .res(res)
	);

	assign empty = !res_valid;
	assign text_char = res.text_char;
	assign last_char = res.last_char;
	assign out_of_range = res.out_of_range;

	a_flag_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_of_range) |-> last_char) else $error("flag without last");
	a_flag_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && out_of_range) |-> (text_char == 7'd0)) else $error("flag char");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(text_char))) else $error("result lost");
endmodule

/* rtl/f2dc_front.sv */
// ----------------------------------------------------------------------------
// f2dc_front
// Accepts float patterns, flags out-of-range values, forms mantissa and
// power-of-two divisor, and queues the job for the back end (two entries).
// ----------------------------------------------------------------------------
module f2dc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  logic [31:0]         float_bits,
	output logic                job_valid,
	input  logic                job_take,
	output f2dc_pkg::job_t      job
);
	logic [7:0] expf;
	logic [7:0] shifts;
	logic [4:0] over;
	f2dc_pkg::job_t new_job;
	f2dc_pkg::job_t slot_q [2];
	logic [1:0] count_q;
	logic       rd_q;
	logic       wr_q;
	logic       do_push;

	assign expf = float_bits[30:23];
	assign shifts = f2dc_pkg::EXP_BIAS_SHIFT - expf;

	always_comb begin
		new_job.flag = float_bits[31] || (expf >= f2dc_pkg::EXP_LIMIT);
		new_job.mant = {1'b1, float_bits[22:0]};
		new_job.divisor = '0;
		over = '0;
		if (shifts <= 8'd30) begin
			new_job.divisor[shifts[4:0]] = 1'b1;
		end else begin
			new_job.divisor = f2dc_pkg::DIV_CAP;
			if (shifts >= 8'd54)
				new_job.mant = '0;
			else begin
				over = 5'(shifts - 8'd30);
				new_job.mant = new_job.mant >> over;
			end
		end
	end

	assign full = (count_q == 2'd2);
	assign do_push = push && !full;
	assign job_valid = (count_q != 2'd0);
	assign job = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_q] <= new_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rd_q <= 1'b0;
			wr_q <= 1'b0;
		end else begin
			if (do_push)
				wr_q <= !wr_q;
			if (job_take && job_valid)
				rd_q <= !rd_q;
			count_q <= count_q + 2'(do_push) - 2'(job_take && job_valid);
		end
	end
endmodule

/* rtl/f2dc_div.sv */
// ----------------------------------------------------------------------------
// f2dc_div
// Radix-2 restoring divider, 35-bit dividend by 31-bit divisor, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module f2dc_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [34:0] dividend,
	input  logic [30:0] divisor,
	output logic        done,
	output logic [34:0] quotient,
	output logic [30:0] remainder
);
	logic [34:0] quo_q;
	logic [31:0] rem_q;
	logic [30:0] dvs_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [31:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q[30:0], quo_q[34]};
	assign diff = {1'b0, trial} - {2'b0, dvs_q};
	assign quotient = quo_q;
	assign remainder = rem_q[30:0];

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[33:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[33:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 6'd35;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end
endmodule

/* rtl/f2dc_back.sv */
// ----------------------------------------------------------------------------
// f2dc_back
// Divides out the integer part and emits its digits, the point and the
// fraction digits (or an out-of-range flag) via a one-entry output register.
// ----------------------------------------------------------------------------
module f2dc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [2:0]          decimal_places,
	input  logic                job_valid,
	output logic                job_take,
	input  f2dc_pkg::job_t      job,
	output logic                res_valid,
	input  logic                res_take,
	output f2dc_pkg::res_t      res
);
	f2dc_pkg::back_state_t state_q, state_d;
	logic [30:0] dvs_q;
	logic [31:0] rem_q;
	logic [3:0]  n_q;
	logic [2:0]  places_q;
	logic [3:0]  dig_q [8];
	logic [3:0]  nd_q;
	logic [23:0] iq_q;
	logic        out_free;
	logic        div_start;
	logic [34:0] div_dividend;
	logic [30:0] div_divisor;
	logic        div_done;
	logic [34:0] div_quo;
	logic [30:0] div_rem;
	f2dc_pkg::res_t res_q;
	logic        res_valid_q;
	logic        emit;
	f2dc_pkg::res_t emit_res;
	logic [23:0] iq_div10;
	logic [3:0]  iq_mod10;
	logic        frac_last;
	logic [34:0] prod;
	logic [3:0]  dval;
	logic        frac_adjust;

	assign out_free = !res_valid_q || res_take;
	assign res_valid = res_valid_q;
	assign res = res_q;

	assign iq_div10 = 24'((48'(iq_q) * 48'd13421773) >> 27);
	always_comb begin
		logic [27:0] t;
		t = 28'(iq_q) - 28'(iq_div10) * 28'd10;
		iq_mod10 = t[3:0];
	end

	assign div_divisor = (state_q == f2dc_pkg::ST_IDLE) ? job.divisor : dvs_q;

	f2dc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quotient(div_quo), .remainder(div_rem)
	);

	assign prod = 35'(rem_q) * 35'd10;
	assign dval = (div_quo > 35'd9) ? 4'd9 : div_quo[3:0];
	assign frac_last = (places_q == 3'd1) || (n_q + 4'd1 == f2dc_pkg::MAX_CHARS);
	assign frac_adjust = (rem_q >= f2dc_pkg::RESCALE_LIMIT) || (dvs_q == '0) ||
		(rem_q >= 32'(dvs_q));

	always_comb begin
		state_d = state_q;
		job_take = 1'b0;
		div_start = 1'b0;
		div_dividend = prod;
		emit = 1'b0;
		emit_res = '0;
		unique case (state_q)
			f2dc_pkg::ST_IDLE: begin
				if (job_valid) begin
					job_take = 1'b1;
					if (job.flag)
						state_d = f2dc_pkg::ST_FLAG;
					else begin
						div_start = 1'b1;
						div_dividend = 35'(job.mant);
						state_d = f2dc_pkg::ST_DIV;
					end
				end
			end
			f2dc_pkg::ST_DIV: begin
				if (div_done)
					state_d = f2dc_pkg::ST_INT;
			end
			f2dc_pkg::ST_INT: begin
				if (iq_q == '0 || nd_q == 4'd8)
					state_d = f2dc_pkg::ST_DOT;
			end
			f2dc_pkg::ST_DOT: begin
				if (out_free) begin
					emit = 1'b1;
					if (nd_q != 4'd0)
						emit_res.text_char = f2dc_pkg::CHAR_ZERO + 7'(dig_q[nd_q[2:0] - 3'd1]);
					else begin
						emit_res.text_char = f2dc_pkg::CHAR_DOT;
						emit_res.last_char = (places_q == 3'd0) || (n_q + 4'd1 == f2dc_pkg::MAX_CHARS);
						state_d = emit_res.last_char ? f2dc_pkg::ST_IDLE : f2dc_pkg::ST_FRAC_PREP;
					end
				end
			end
			f2dc_pkg::ST_FRAC_PREP: begin
				if (!frac_adjust) begin
					div_start = 1'b1;
					state_d = f2dc_pkg::ST_FRAC_DIV;
				end
			end
			f2dc_pkg::ST_FRAC_DIV: begin
				if (out_free && !div_start && state_q == f2dc_pkg::ST_FRAC_DIV && iq_q == 24'd1) begin
					emit = 1'b1;
					emit_res.text_char = f2dc_pkg::CHAR_ZERO + 7'(dig_q[0]);
					emit_res.last_char = frac_last;
					state_d = frac_last ? f2dc_pkg::ST_IDLE : f2dc_pkg::ST_FRAC_PREP;
				end
			end
			f2dc_pkg::ST_FLAG: begin
				if (out_free) begin
					emit = 1'b1;
					emit_res.last_char = 1'b1;
					emit_res.out_of_range = 1'b1;
					state_d = f2dc_pkg::ST_IDLE;
				end
			end
			default: state_d = f2dc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit)
			res_q <= emit_res;
		unique case (state_q)
			f2dc_pkg::ST_IDLE: begin
				dvs_q <= job.divisor;
				places_q <= decimal_places;
				n_q <= '0;
				nd_q <= '0;
			end
			f2dc_pkg::ST_DIV: begin
				if (div_done) begin
					iq_q <= div_quo[23:0];
					rem_q <= 32'(div_rem);
				end
			end
			f2dc_pkg::ST_INT: begin
				if (!(iq_q == '0 || nd_q == 4'd8)) begin
					dig_q[nd_q[2:0]] <= iq_mod10;
					nd_q <= nd_q + 4'd1;
					iq_q <= iq_div10;
				end else if (nd_q == 4'd0) begin
					dig_q[0] <= 4'd0;
					nd_q <= 4'd1;
				end
			end
			f2dc_pkg::ST_DOT: begin
				if (emit) begin
					n_q <= n_q + 4'd1;
					if (nd_q != 4'd0)
						nd_q <= nd_q - 4'd1;
				end
			end
			f2dc_pkg::ST_FRAC_PREP: begin
				iq_q <= '0;
				if (rem_q >= f2dc_pkg::RESCALE_LIMIT) begin
					rem_q <= 32'((64'(rem_q) * 64'd3435973837) >> 35);
					dvs_q <= 31'((64'(dvs_q) * 64'd3435973837) >> 35);
				end else if (dvs_q == '0) begin
					dvs_q <= 31'd1;
					rem_q <= '0;
				end else if (rem_q >= 32'(dvs_q)) begin
					rem_q <= 32'(dvs_q) - 32'd1;
				end
			end
			f2dc_pkg::ST_FRAC_DIV: begin
				if (div_done) begin
					dig_q[0] <= dval;
					rem_q <= 32'(div_rem);
					iq_q <= 24'd1;
				end
				if (emit) begin
					n_q <= n_q + 4'd1;
					places_q <= places_q - 3'd1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= f2dc_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit)
				res_valid_q <= 1'b1;
			else if (res_take)
				res_valid_q <= 1'b0;
		end
	end
endmodule
